@@ design/assert_macros.svh @@
// Assertion helpers for the RTL, included by the top-level bridge. Both sample on clk_i and
// stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge requires the consequent at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/dmdhb_pkg.sv @@
package dmdhb_pkg;

  // Field widths fixed by the port list
  localparam int KIND_W = 2;
  localparam int PIX_W  = 16;
  localparam int ROW_W  = 4;
  localparam int SLOT_W = 3;
  localparam int BUF_W  = 2;
  localparam int CNT_W  = 32;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_WORD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STROBE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Result kind codes
  localparam logic RES_STATUS = 1'b0;
  localparam logic RES_WORD   = 1'b1;

  // Row pair whose scan retires the ready frame
  localparam logic [ROW_W-1:0] LAST_ROW_PAIR = 4'd15;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_STROBE,
    OP_SCAN
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [PIX_W-1:0] data;
    logic             fend;
    logic [ROW_W-1:0] row;
  } q_entry_t;

endpackage

@@ design/dmdhb_ram.sv @@
module dmdhb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/dmdhb_front.sv @@
module dmdhb_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dmdhb_pkg::KIND_W-1:0]   kind_i,
  input  logic [dmdhb_pkg::PIX_W-1:0]    data_word_i,
  input  logic                           frame_end_flag_i,
  input  logic [dmdhb_pkg::ROW_W-1:0]    row_pair_i,
  input  logic                           clearing_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output dmdhb_pkg::q_entry_t            entry_o
);

  logic accept;

  // Hold off while the store is being cleared or the queue is full
  assign in_stall_o = clearing_i | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Classify the request; the unused kind is taken and dropped here
  always_comb begin
    entry_o.data = data_word_i;
    entry_o.fend = frame_end_flag_i;
    entry_o.row  = row_pair_i;
    entry_o.op   = dmdhb_pkg::OP_WRITE;
    push_o       = 1'b0;
    case (kind_i)
      dmdhb_pkg::KIND_WORD: begin
        entry_o.op = dmdhb_pkg::OP_WRITE;
        push_o     = accept;
      end
      dmdhb_pkg::KIND_STROBE: begin
        entry_o.op = dmdhb_pkg::OP_STROBE;
        push_o     = accept;
      end
      dmdhb_pkg::KIND_SCAN: begin
        entry_o.op = dmdhb_pkg::OP_SCAN;
        push_o     = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

@@ design/dmdhb_fifo.sv @@
module dmdhb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dmdhb_pkg::q_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output dmdhb_pkg::q_entry_t head_o
);

  dmdhb_pkg::q_entry_t               slots_q [dmdhb_pkg::QUEUE_DEPTH];
  logic [dmdhb_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dmdhb_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dmdhb_pkg::QPTR_W:0]        count_q, count_d;

  assign full_o  = (count_q == (dmdhb_pkg::QPTR_W+1)'(dmdhb_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ design/dmdhb_back.sv @@
module dmdhb_back #(
  parameter int BUFFERS        = 3,
  parameter int LINES          = 32,
  parameter int WORDS_PER_LINE = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  dmdhb_pkg::q_entry_t            q_head_i,
  output logic                           q_pop_o,
  output logic                           clearing_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           result_kind_o,
  output logic [dmdhb_pkg::ROW_W-1:0]    row_address_o,
  output logic [dmdhb_pkg::SLOT_W-1:0]   word_slot_o,
  output logic [dmdhb_pkg::PIX_W-1:0]    top_word_o,
  output logic [dmdhb_pkg::PIX_W-1:0]    bottom_word_o,
  output logic                           last_o,
  output logic                           frame_done_o,
  output logic                           frame_ready_o,
  output logic [dmdhb_pkg::BUF_W-1:0]    shown_buffer_o,
  output logic [dmdhb_pkg::CNT_W-1:0]    frames_seen_o
);

  localparam int LW    = $clog2(LINES);
  localparam int WW    = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int WCW   = $clog2(WORDS_PER_LINE + 1);
  localparam int AW    = dmdhb_pkg::BUF_W + LW + WW;
  localparam int DEPTH = 1 << AW;
  localparam int LUT_N = 1 << (dmdhb_pkg::ROW_W + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SCAN
  } state_e;

  // Result fields waiting for read data
  typedef struct packed {
    logic                          kind;
    logic [dmdhb_pkg::ROW_W-1:0]   row;
    logic [dmdhb_pkg::SLOT_W-1:0]  slot;
    logic                          last;
    logic                          done;
    logic                          ready;
    logic [dmdhb_pkg::BUF_W-1:0]   shown;
    logic [dmdhb_pkg::CNT_W-1:0]   frames;
  } meta_t;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 clr_addr_q, clr_addr_d;
  logic [dmdhb_pkg::BUF_W-1:0]   fill_q, fill_d;
  logic [dmdhb_pkg::BUF_W-1:0]   ready_buf_q, ready_buf_d;
  logic [LW-1:0]                 line_q, line_d;
  logic [WCW-1:0]                word_q, word_d;
  logic                          ready_flag_q, ready_flag_d;
  logic [dmdhb_pkg::CNT_W-1:0]   frames_q, frames_d;
  logic [dmdhb_pkg::ROW_W-1:0]   scan_row_q, scan_row_d;
  logic [LW-1:0]                 top_line_q, top_line_d;
  logic [LW-1:0]                 bot_line_q, bot_line_d;
  logic [WW-1:0]                 slot_q, slot_d;
  logic                          s1_valid_q, s1_valid_d;
  meta_t                         s1_q, s1_d;
  logic                          out_valid_q, out_valid_d;
  meta_t                         out_q, out_d;
  logic [dmdhb_pkg::PIX_W-1:0]   top_q, top_d;
  logic [dmdhb_pkg::PIX_W-1:0]   bot_q, bot_d;

  logic                          out_free;
  logic                          advance;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [dmdhb_pkg::PIX_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 top_raddr;
  logic [AW-1:0]                 bot_raddr;
  logic [dmdhb_pkg::PIX_W-1:0]   top_rdata;
  logic [dmdhb_pkg::PIX_W-1:0]   bot_rdata;
  logic [LW-1:0]                 line_mod [LUT_N];

  // Row pair to stored line, wrapped by the line count; upper half is row plus 16
  for (genvar g = 0; g < LUT_N; g++) begin : g_line_mod
    assign line_mod[g] = LW'(g % LINES);
  end

  // Two copies of the frame store, one read port each
  dmdhb_ram #(
    .WIDTH (dmdhb_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_ram_top (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (top_raddr),
    .rdata_o (top_rdata)
  );

  dmdhb_ram #(
    .WIDTH (dmdhb_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_ram_bot (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (bot_raddr),
    .rdata_o (bot_rdata)
  );

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = ~s1_valid_q | out_free;
  assign clearing_o = (state_q == ST_CLEAR);
  assign top_raddr  = {ready_buf_q, top_line_q, slot_q};
  assign bot_raddr  = {ready_buf_q, bot_line_q, slot_q};

  // Sequence the queued requests
  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    fill_d       = fill_q;
    ready_buf_d  = ready_buf_q;
    line_d       = line_q;
    word_d       = word_q;
    ready_flag_d = ready_flag_q;
    frames_d     = frames_q;
    scan_row_d   = scan_row_q;
    top_line_d   = top_line_q;
    bot_line_d   = bot_line_q;
    slot_d       = slot_q;
    s1_valid_d   = s1_valid_q & ~out_free;
    s1_d         = s1_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = {fill_q, line_q, word_q[WW-1:0]};
    mem_wdata    = q_head_i.data;
    mem_re       = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // Zero the whole store, one entry a cycle
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == {AW{1'b1}}) begin
          state_d = ST_RUN;
        end
      end

      ST_RUN: begin
        if (!q_empty_i) begin
          case (q_head_i.op)
            dmdhb_pkg::OP_WRITE: begin
              // Store the word; drop words past the end of the line
              q_pop_o = 1'b1;
              if (word_q < WCW'(WORDS_PER_LINE)) begin
                mem_we = 1'b1;
                word_d = word_q + 1'b1;
              end
            end
            dmdhb_pkg::OP_STROBE: begin
              if (advance) begin
                q_pop_o = 1'b1;
                word_d  = '0;
                if (q_head_i.fend) begin
                  ready_flag_d = 1'b1;
                  ready_buf_d  = fill_q;
                  fill_d       = (fill_q == dmdhb_pkg::BUF_W'(BUFFERS - 1)) ? '0
                                                                         : fill_q + 1'b1;
                  line_d       = '0;
                  frames_d     = frames_q + 1'b1;
                end else if (line_q != LW'(LINES - 1)) begin
                  line_d = line_q + 1'b1;
                end
                s1_valid_d    = 1'b1;
                s1_d.kind     = dmdhb_pkg::RES_STATUS;
                s1_d.row      = '0;
                s1_d.slot     = '0;
                s1_d.last     = 1'b0;
                s1_d.done     = q_head_i.fend;
                s1_d.ready    = ready_flag_d;
                s1_d.shown    = ready_buf_d;
                s1_d.frames   = frames_d;
              end
            end
            dmdhb_pkg::OP_SCAN: begin
              // Latch the row pair and its two lines
              q_pop_o    = 1'b1;
              scan_row_d = q_head_i.row;
              top_line_d = line_mod[{1'b0, q_head_i.row}];
              bot_line_d = line_mod[{1'b1, q_head_i.row}];
              slot_d     = '0;
              state_d    = ST_SCAN;
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one word pair read per cycle while the read stage can advance
        if (advance) begin
          mem_re      = 1'b1;
          s1_valid_d  = 1'b1;
          s1_d.kind   = dmdhb_pkg::RES_WORD;
          s1_d.row    = scan_row_q;
          s1_d.slot   = dmdhb_pkg::SLOT_W'(slot_q);
          s1_d.last   = (slot_q == WW'(WORDS_PER_LINE - 1));
          s1_d.done   = 1'b0;
          s1_d.ready  = ready_flag_q;
          s1_d.shown  = ready_buf_q;
          s1_d.frames = frames_q;
          slot_d      = slot_q + 1'b1;
          if (slot_q == WW'(WORDS_PER_LINE - 1)) begin
            state_d = ST_RUN;
            if (scan_row_q == dmdhb_pkg::LAST_ROW_PAIR) begin
              ready_flag_d = 1'b0;
            end
          end
        end
      end

      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Load the output register from the read stage
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    top_d       = top_q;
    bot_d       = bot_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
      out_d       = s1_q;
      if (s1_q.kind == dmdhb_pkg::RES_WORD) begin
        top_d = top_rdata;
        bot_d = bot_rdata;
      end else begin
        top_d = '0;
        bot_d = '0;
      end
    end
  end

  // Hold state, read stage and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      fill_q       <= '0;
      ready_buf_q  <= '0;
      line_q       <= '0;
      word_q       <= '0;
      ready_flag_q <= 1'b0;
      frames_q     <= '0;
      scan_row_q   <= '0;
      top_line_q   <= '0;
      bot_line_q   <= '0;
      slot_q       <= '0;
      s1_valid_q   <= 1'b0;
      s1_q         <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      top_q        <= '0;
      bot_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      fill_q       <= fill_d;
      ready_buf_q  <= ready_buf_d;
      line_q       <= line_d;
      word_q       <= word_d;
      ready_flag_q <= ready_flag_d;
      frames_q     <= frames_d;
      scan_row_q   <= scan_row_d;
      top_line_q   <= top_line_d;
      bot_line_q   <= bot_line_d;
      slot_q       <= slot_d;
      s1_valid_q   <= s1_valid_d;
      s1_q         <= s1_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      top_q        <= top_d;
      bot_q        <= bot_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign row_address_o  = out_q.row;
  assign word_slot_o    = out_q.slot;
  assign top_word_o     = top_q;
  assign bottom_word_o  = bot_q;
  assign last_o         = out_q.last;
  assign frame_done_o   = out_q.done;
  assign frame_ready_o  = out_q.ready;
  assign shown_buffer_o = out_q.shown;
  assign frames_seen_o  = out_q.frames;

endmodule

@@ design/dmd_to_hub75_frame_bridge.sv @@
// Channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid_i / in_stall_o   | kind, data_word, frame_end_flag, row_pair
// output   | out_valid_o / out_stall_i | result_kind .. frames_seen
//
// After reset the frame store is zeroed one entry a cycle, all 2**(2 + clog2(LINES)
// + max(1, clog2(WORDS_PER_LINE))) entries (1024 at the defaults); input stalls meanwhile.
// A data word or a strobe is handled as it is popped; a scan latches the row pair, then
// reads one word pair per cycle from the two store ports while the read stage advances.
// A four-entry request queue lets the input run ahead of the back end.
// Output stall backs up through the read stage into the queue, then the input.
module dmd_to_hub75_frame_bridge #(
  parameter int BUFFERS        = 3,
  parameter int LINES          = 32,
  parameter int WORDS_PER_LINE = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dmdhb_pkg::KIND_W-1:0]   kind_i,
  input  logic [dmdhb_pkg::PIX_W-1:0]    data_word_i,
  input  logic                           frame_end_flag_i,
  input  logic [dmdhb_pkg::ROW_W-1:0]    row_pair_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           result_kind_o,
  output logic [dmdhb_pkg::ROW_W-1:0]    row_address_o,
  output logic [dmdhb_pkg::SLOT_W-1:0]   word_slot_o,
  output logic [dmdhb_pkg::PIX_W-1:0]    top_word_o,
  output logic [dmdhb_pkg::PIX_W-1:0]    bottom_word_o,
  output logic                           last_o,
  output logic                           frame_done_o,
  output logic                           frame_ready_o,
  output logic [dmdhb_pkg::BUF_W-1:0]    shown_buffer_o,
  output logic [dmdhb_pkg::CNT_W-1:0]    frames_seen_o
);

  `include "assert_macros.svh"

  logic                clearing;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  dmdhb_pkg::q_entry_t q_entry;
  dmdhb_pkg::q_entry_t q_head;

  dmdhb_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .data_word_i      (data_word_i),
    .frame_end_flag_i (frame_end_flag_i),
    .row_pair_i       (row_pair_i),
    .clearing_i       (clearing),
    .q_full_i         (q_full),
    .push_o           (q_push),
    .entry_o          (q_entry)
  );

  dmdhb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  dmdhb_back #(
    .BUFFERS        (BUFFERS),
    .LINES          (LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .row_address_o  (row_address_o),
    .word_slot_o    (word_slot_o),
    .top_word_o     (top_word_o),
    .bottom_word_o  (bottom_word_o),
    .last_o         (last_o),
    .frame_done_o   (frame_done_o),
    .frame_ready_o  (frame_ready_o),
    .shown_buffer_o (shown_buffer_o),
    .frames_seen_o  (frames_seen_o)
  );

  `ASSERT_IMPLIES(a_clear_quiet, clearing, in_stall_o && !out_valid_o && !q_pop, "activity during store clear")
  `ASSERT_ALWAYS(a_no_pop_empty, !(q_pop && q_empty), "request queue popped while empty")
  `ASSERT_IMPLIES(a_last_slot, out_valid_o && (result_kind_o == dmdhb_pkg::RES_WORD) && last_o, word_slot_o == dmdhb_pkg::SLOT_W'(WORDS_PER_LINE - 1), "last flag on wrong word slot")
  `ASSERT_IMPLIES(a_status_blank, out_valid_o && (result_kind_o == dmdhb_pkg::RES_STATUS), (top_word_o == '0) && (bottom_word_o == '0) && !last_o, "strobe status carries pixel data")

endmodule

@@ sim/dmdhb_checker.sv @@
module dmdhb_checker
  import dmdhb_pkg::*;
#(
  parameter int BUFFERS        = 3,
  parameter int LINES          = 32,
  parameter int WORDS_PER_LINE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [PIX_W-1:0]  data_word_i,
  input  logic              frame_end_flag_i,
  input  logic [ROW_W-1:0]  row_pair_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              result_kind_i,
  input  logic [ROW_W-1:0]  row_address_i,
  input  logic [SLOT_W-1:0] word_slot_i,
  input  logic [PIX_W-1:0]  top_word_i,
  input  logic [PIX_W-1:0]  bottom_word_i,
  input  logic              last_i,
  input  logic              frame_done_i,
  input  logic              frame_ready_i,
  input  logic [BUF_W-1:0]  shown_buffer_i,
  input  logic [CNT_W-1:0]  frames_seen_i,
  output int                fail_count_o,
  output int                pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOTTOM_OFFSET = 16;
  localparam int STORE_WORDS   = BUFFERS * LINES * WORDS_PER_LINE;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic [PIX_W-1:0]  top_pix;
    logic [PIX_W-1:0]  bottom_pix;
    logic              last_word;
    logic              done;
    logic              ready;
    logic [BUF_W-1:0]  shown;
    logic [CNT_W-1:0]  frames;
  } panel_result_t;

  // Shadow of the frame store and the capture/scan state
  logic [PIX_W-1:0] frame_copy [STORE_WORDS];
  int               fill_buf;
  int               ready_buf;
  int               line_pos;
  int               word_pos;
  logic             ready_flag;
  logic [CNT_W-1:0] frame_count;

  panel_result_t    pending_results[$];
  panel_result_t    want;
  int               fails;
  int               idx;

  function automatic int store_index(int buf_sel, int line, int word);
    return ((buf_sel % BUFFERS) * LINES + (line % LINES)) * WORDS_PER_LINE
           + (word % WORDS_PER_LINE);
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fails++;
    end
  endtask

  // Apply one request to the shadow state and queue the results it causes
  task automatic predict_panel_results(input logic [KIND_W-1:0] kind,
                                       input logic [PIX_W-1:0] word,
                                       input logic fend,
                                       input logic [ROW_W-1:0] row);
    panel_result_t res;
    int            top_line;
    int            bot_line;
    int            k;
    res = '0;
    case (kind)
      KIND_WORD: begin
        // drop words past the end of the line
        if (word_pos < WORDS_PER_LINE) begin
          frame_copy[store_index(fill_buf, line_pos, word_pos)] = word;
          word_pos++;
        end
      end
      KIND_STROBE: begin
        word_pos = 0;
        if (fend) begin
          ready_flag  = 1'b1;
          ready_buf   = fill_buf;
          fill_buf    = (fill_buf + 1) % BUFFERS;
          line_pos    = 0;
          frame_count = frame_count + 1'b1;
        end else if (line_pos >= LINES - 1) begin
          line_pos = LINES - 1;
        end else begin
          line_pos++;
        end
        res.kind   = RES_STATUS;
        res.done   = fend;
        res.ready  = ready_flag;
        res.shown  = BUF_W'(ready_buf);
        res.frames = frame_count;
        pending_results.push_back(res);
      end
      KIND_SCAN: begin
        top_line = int'(row) % LINES;
        bot_line = (int'(row) + BOTTOM_OFFSET) % LINES;
        for (k = 0; k < WORDS_PER_LINE; k++) begin
          res.kind       = RES_WORD;
          res.row        = row;
          res.slot       = SLOT_W'(k);
          res.top_pix    = frame_copy[store_index(ready_buf, top_line, k)];
          res.bottom_pix = frame_copy[store_index(ready_buf, bot_line, k)];
          res.last_word  = (k == WORDS_PER_LINE - 1);
          res.done       = 1'b0;
          res.ready      = ready_flag;
          res.shown      = BUF_W'(ready_buf);
          res.frames     = frame_count;
          pending_results.push_back(res);
        end
        // retire the frame after the last row pair
        if (row == LAST_ROW_PAIR) begin
          ready_flag = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Track requests, compare results in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (idx = 0; idx < STORE_WORDS; idx++) begin
        frame_copy[idx] = '0;
      end
      fill_buf     = 0;
      ready_buf    = 0;
      line_pos     = 0;
      word_pos     = 0;
      ready_flag   = 1'b0;
      frame_count  = '0;
      fails        = 0;
      pending_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_panel_results(kind_i, data_word_i, frame_end_flag_i, row_pair_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d row %0d slot %0d",
                   $time, result_kind_i, row_address_i, word_slot_i);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", want.kind, result_kind_i);
          check_field("row_address", want.row, row_address_i);
          check_field("word_slot", want.slot, word_slot_i);
          check_field("top_word", want.top_pix, top_word_i);
          check_field("bottom_word", want.bottom_pix, bottom_word_i);
          check_field("last", want.last_word, last_i);
          check_field("frame_done", want.done, frame_done_i);
          check_field("frame_ready", want.ready, frame_ready_i);
          check_field("shown_buffer", want.shown, shown_buffer_i);
          check_field("frames_seen", want.frames, frames_seen_i);
        end
      end
      pending_o    <= pending_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ sim/tb_dmd_to_hub75_frame_bridge.sv @@
module tb_dmd_to_hub75_frame_bridge;

  timeunit 1ns;
  timeprecision 1ps;

  import dmdhb_pkg::*;

  localparam int BUFFERS        = 3;
  localparam int LINES          = 32;
  localparam int WORDS_PER_LINE = 8;
  localparam int RANDOM_ITEMS   = 310;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] kind           = KIND_WORD;
  logic [PIX_W-1:0]  data_word      = '0;
  logic              frame_end_flag = 1'b0;
  logic [ROW_W-1:0]  row_pair       = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              result_kind;
  logic [ROW_W-1:0]  row_address;
  logic [SLOT_W-1:0] word_slot;
  logic [PIX_W-1:0]  top_word;
  logic [PIX_W-1:0]  bottom_word;
  logic              last_flag;
  logic              frame_done;
  logic              frame_ready;
  logic [BUF_W-1:0]  shown_buffer;
  logic [CNT_W-1:0]  frames_seen;

  int                fail_count;
  int                pending;
  int                sent_items     = 0;
  logic              quiet_run      = 1'b0;

  always #6 clk = ~clk;

  dmd_to_hub75_frame_bridge #(
    .BUFFERS        (BUFFERS),
    .LINES          (LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .data_word_i      (data_word),
    .frame_end_flag_i (frame_end_flag),
    .row_pair_i       (row_pair),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_kind_o    (result_kind),
    .row_address_o    (row_address),
    .word_slot_o      (word_slot),
    .top_word_o       (top_word),
    .bottom_word_o    (bottom_word),
    .last_o           (last_flag),
    .frame_done_o     (frame_done),
    .frame_ready_o    (frame_ready),
    .shown_buffer_o   (shown_buffer),
    .frames_seen_o    (frames_seen)
  );

  dmdhb_checker #(
    .BUFFERS        (BUFFERS),
    .LINES          (LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .data_word_i      (data_word),
    .frame_end_flag_i (frame_end_flag),
    .row_pair_i       (row_pair),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .result_kind_i    (result_kind),
    .row_address_i    (row_address),
    .word_slot_i      (word_slot),
    .top_word_i       (top_word),
    .bottom_word_i    (bottom_word),
    .last_i           (last_flag),
    .frame_done_i     (frame_done),
    .frame_ready_i    (frame_ready),
    .shown_buffer_i   (shown_buffer),
    .frames_seen_i    (frames_seen),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // Stall the result side at random, except during the quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet_run && ($urandom_range(0, 99) < 26);
  end

  // Pixel words lean on the all-clear and all-set patterns now and then
  function automatic logic [PIX_W-1:0] pixel_pattern();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Hold one request until accepted, with random idle cycles ahead of it
  task automatic push_request(input logic [KIND_W-1:0] k, input logic [PIX_W-1:0] w,
                              input logic f, input logic [ROW_W-1:0] r);
    while (!quiet_run && ($urandom_range(0, 99) < 26)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    data_word      <= w;
    frame_end_flag <= f;
    row_pair       <= r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (k != KIND_UNUSED) begin
      sent_items++;
    end
  endtask

  // End the run if it hangs
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int pick;
    int n_lines;
    int n_words;
    int n_scans;
    int ln;
    int wd;
    int sc;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill line 0 of buffer 0 with edge patterns, then one word too many
    push_request(KIND_WORD, 16'hFFFF, 1'b0, 4'd0);
    push_request(KIND_WORD, 16'h0000, 1'b1, 4'd15);
    push_request(KIND_WORD, 16'h8001, 1'b0, 4'd0);
    push_request(KIND_WORD, 16'h7FFE, 1'b1, 4'd15);
    push_request(KIND_WORD, 16'hAAAA, 1'b0, 4'd5);
    push_request(KIND_WORD, 16'h5555, 1'b1, 4'd10);
    push_request(KIND_WORD, 16'h0001, 1'b0, 4'd3);
    push_request(KIND_WORD, 16'h8000, 1'b1, 4'd12);
    push_request(KIND_WORD, 16'h1234, 1'b0, 4'd0);
    // advance to line 1, write a word, then close the frame
    push_request(KIND_STROBE, 16'hFFFF, 1'b0, 4'd15);
    push_request(KIND_WORD, 16'hC3C3, 1'b0, 4'd0);
    push_request(KIND_STROBE, 16'h0000, 1'b1, 4'd0);
    // scan the ready frame, retire it, then scan with nothing ready
    push_request(KIND_SCAN, 16'hFFFF, 1'b1, 4'd0);
    push_request(KIND_SCAN, 16'h0000, 1'b0, 4'd1);
    push_request(KIND_SCAN, 16'h0000, 1'b0, LAST_ROW_PAIR);
    push_request(KIND_SCAN, 16'hFFFF, 1'b1, 4'd7);
    // an unused kind must change nothing
    push_request(KIND_UNUSED, 16'hFFFF, 1'b1, 4'd15);
    // word slot restarts after a strobe; rotate the fill buffer back around
    push_request(KIND_WORD, 16'h0F0F, 1'b0, 4'd0);
    push_request(KIND_STROBE, 16'h0000, 1'b1, 4'd0);
    push_request(KIND_STROBE, 16'h0000, 1'b1, 4'd0);
    push_request(KIND_SCAN, 16'h0000, 1'b0, 4'd0);
    push_request(KIND_STROBE, 16'h0000, 1'b1, 4'd0);
    push_request(KIND_SCAN, 16'h0000, 1'b0, 4'd0);

    // Random frames, scan bursts and noise
    while (sent_items < RANDOM_ITEMS) begin
      quiet_run <= (sent_items >= 150) && (sent_items < 230);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // mostly short frames, some long enough to saturate the line count
        n_lines = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 20);
        for (ln = 0; ln < n_lines; ln++) begin
          n_words = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
          for (wd = 0; wd < n_words; wd++) begin
            push_request(KIND_WORD, pixel_pattern(), 1'($urandom), ROW_W'($urandom));
          end
          push_request(KIND_STROBE, PIX_W'($urandom), 1'b0, ROW_W'($urandom));
        end
        // leave a frame open now and then
        if ($urandom_range(0, 7) != 0) begin
          push_request(KIND_STROBE, PIX_W'($urandom), 1'b1, ROW_W'($urandom));
        end
        n_scans = $urandom_range(1, 5);
        for (sc = 0; sc < n_scans; sc++) begin
          push_request(KIND_SCAN, PIX_W'($urandom), 1'($urandom), ROW_W'($urandom));
        end
        if ($urandom_range(0, 2) == 0) begin
          push_request(KIND_SCAN, PIX_W'($urandom), 1'($urandom), LAST_ROW_PAIR);
        end
      end else if (pick < 80) begin
        n_scans = $urandom_range(1, 4);
        for (sc = 0; sc < n_scans; sc++) begin
          push_request(KIND_SCAN, PIX_W'($urandom), 1'($urandom), ROW_W'($urandom));
        end
      end else begin
        n_words = $urandom_range(1, 6);
        for (wd = 0; wd < n_words; wd++) begin
          push_request(KIND_W'($urandom), PIX_W'($urandom), 1'($urandom), ROW_W'($urandom));
        end
      end
    end
    in_valid  <= 1'b0;
    quiet_run <= 1'b0;

    // Drain outstanding results, then watch for strays
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (64) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
